// File: hw/rtl/multichannel_overwrite_ring_buffer_top_assert.svh
// ----------------------------------------------------------------------------
// Multichannel overwrite ring buffer - assertion macros
// Clocked implication checks used by the top module.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_OVERWRITE_RING_BUFFER_TOP_ASSERT_SVH
`define MULTICHANNEL_OVERWRITE_RING_BUFFER_TOP_ASSERT_SVH

// same-cycle implication
`define MCORB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcorb: same-cycle check failed");

// next-cycle implication
`define MCORB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcorb: next-cycle check failed");

`endif

// File: hw/rtl/mcorb_pkg.sv
// ----------------------------------------------------------------------------
// mcorb_pkg
// Types, codes and widths of the multichannel overwrite ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcorb_pkg;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_MAX_DEPTH    = 1024;
  localparam int DEF_MAX_BURST    = 64;
  localparam int DEF_SAMPLE_WIDTH = 32;

  localparam int REQ_TYPE_W = 1;
  localparam int CHANNEL_W  = 3;
  localparam int SAMPLE_W   = 32;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 2;

  localparam int CHAN_CNT_W = 4;
  localparam int BUF_LEN_W  = 11;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CHAN_CNT_W-1:0] CHAN_CNT_RST = 4'd6;
  localparam logic [BUF_LEN_W-1:0]  BUF_LEN_RST  = 11'd600;

  typedef enum logic [STATUS_W-1:0] {
    STAT_WRITE = 2'd0,
    STAT_DATA  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_BAD   = 2'd3
  } status_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

  typedef enum logic {
    REG_CHAN_CNT = 1'b0,
    REG_BUF_LEN  = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WADV,
    ST_WDROP,
    ST_WRES,
    ST_RADDR,
    ST_RDATA
  } state_e;

  typedef struct packed {
    logic [CHAN_CNT_W-1:0] chan_cnt;
    logic [BUF_LEN_W-1:0]  buf_len;
    logic                  clear;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/mcorb_if.sv
// ----------------------------------------------------------------------------
// mcorb_if
// Request and result channels, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcorb_req_if;
  import mcorb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [CHANNEL_W-1:0]  channel;
  logic [SAMPLE_W-1:0]   sample;
  logic [COUNT_W-1:0]    max_count;

  modport source (output valid, req_type, channel, sample, max_count, input ready);
  modport sink   (input valid, req_type, channel, sample, max_count, output ready);
endinterface

interface mcorb_rsp_if;
  import mcorb_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SAMPLE_W-1:0] read_data;
  logic [COUNT_W-1:0]  read_count;
  logic                last;
  logic                loss_flag;

  modport source (output valid, status, read_data, read_count, last, loss_flag,
                  input ready);
  modport sink   (input valid, status, read_data, read_count, last, loss_flag,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/multichannel_overwrite_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// multichannel_overwrite_ring_buffer_top
// Per-channel sample rings that overwrite the oldest sample when full.
// ----------------------------------------------------------------------------
// One request is worked at a time. A write runs ST_LOOK, ST_WADV, ST_WRES,
// with ST_WDROP before ST_WRES when the ring is full and the oldest sample
// is dropped; a read runs ST_RADDR and ST_RDATA once per sample after
// ST_LOOK, and an empty or bad channel is answered in ST_LOOK. Pointer
// advances share the one advance/compare unit, and samples come through the
// registered read port of the sample memory. Results sit in an output
// register, so a stalled result holds only the sequencer, and a read takes
// no new sample until the last one is in that register. A ring holds at
// most its length minus one unread samples; any register write clears every
// pointer and loss flag at once; the sample memory needs no clearing pass.
`default_nettype none

`include "multichannel_overwrite_ring_buffer_top_assert.svh"

module multichannel_overwrite_ring_buffer_top #(
  parameter int MAX_CHANNELS = mcorb_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_DEPTH    = mcorb_pkg::DEF_MAX_DEPTH,
  parameter int MAX_BURST    = mcorb_pkg::DEF_MAX_BURST,
  parameter int SAMPLE_WIDTH = mcorb_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  mcorb_req_if.sink                         req_i,
  mcorb_rsp_if.source                       rsp_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mcorb_pkg::APB_AW-1:0] paddr,
  input  wire logic [mcorb_pkg::APB_DW-1:0] pwdata,
  output logic      [mcorb_pkg::APB_DW-1:0] prdata,
  output logic                              pready
);
  import mcorb_pkg::*;

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PTR_W  = $clog2(MAX_DEPTH);
  localparam int LEN_W  = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W = CH_W + PTR_W;

  cfg_t                    cfg;
  logic [PTR_W-1:0]        adv_ptr;
  logic [PTR_W-1:0]        adv_other;
  logic [LEN_W-1:0]        adv_len;
  logic [PTR_W-1:0]        adv_next;
  logic                    adv_hit;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [SAMPLE_WIDTH-1:0] mem_wdata;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_raddr;
  logic [SAMPLE_WIDTH-1:0] mem_rdata;

  mcorb_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  mcorb_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mcorb_adv #(
    .PTR_W (PTR_W),
    .LEN_W (LEN_W)
  ) u_adv (
    .ptr_i   (adv_ptr),
    .other_i (adv_other),
    .len_i   (adv_len),
    .next_o  (adv_next),
    .hit_o   (adv_hit)
  );

  mcorb_seq #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_DEPTH    (MAX_DEPTH),
    .MAX_BURST    (MAX_BURST),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .adv_ptr_o   (adv_ptr),
    .adv_other_o (adv_other),
    .adv_len_o   (adv_len),
    .adv_next_i  (adv_next),
    .adv_hit_i   (adv_hit),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  `MCORB_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)
  `MCORB_ASSERT_IMP(a_status_last, clk_i, rst_ni, rsp_o.valid && (rsp_o.status != STAT_DATA), rsp_o.last)
  `MCORB_ASSERT_IMP(a_bad_clean, clk_i, rst_ni, rsp_o.valid && (rsp_o.status == STAT_BAD), (rsp_o.read_data == '0) && !rsp_o.loss_flag && (rsp_o.read_count == '0))
  `MCORB_ASSERT_IMP(a_data_count, clk_i, rst_ni, rsp_o.valid && (rsp_o.status == STAT_DATA), rsp_o.read_count != '0)

endmodule

`default_nettype wire

// File: hw/rtl/mcorb_cfg.sv
// ----------------------------------------------------------------------------
// mcorb_cfg
// APB register file: active channel count and ring length.
// ----------------------------------------------------------------------------
`default_nettype none

module mcorb_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel_i,
  input  wire logic                        penable_i,
  input  wire logic                        pwrite_i,
  input  wire logic [mcorb_pkg::APB_AW-1:0] paddr_i,
  input  wire logic [mcorb_pkg::APB_DW-1:0] pwdata_i,
  output logic      [mcorb_pkg::APB_DW-1:0] prdata_o,
  output logic                             pready_o,
  output mcorb_pkg::cfg_t                  cfg_o
);
  import mcorb_pkg::*;

  logic [CHAN_CNT_W-1:0] chan_cnt_q, chan_cnt_d;
  logic [BUF_LEN_W-1:0]  buf_len_q, buf_len_d;
  logic                  wr_en;
  reg_e                  sel;

  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign sel      = reg_e'(paddr_i[2]);
  assign pready_o = 1'b1;

  always_comb begin
    chan_cnt_d = chan_cnt_q;
    buf_len_d  = buf_len_q;
    if (wr_en) begin
      unique case (sel)
        REG_CHAN_CNT: chan_cnt_d = pwdata_i[CHAN_CNT_W-1:0];
        REG_BUF_LEN:  buf_len_d  = pwdata_i[BUF_LEN_W-1:0];
        default:      chan_cnt_d = chan_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= CHAN_CNT_RST;
      buf_len_q  <= BUF_LEN_RST;
    end else begin
      chan_cnt_q <= chan_cnt_d;
      buf_len_q  <= buf_len_d;
    end
  end

  always_comb begin
    unique case (sel)
      REG_CHAN_CNT: prdata_o = APB_DW'(chan_cnt_q);
      REG_BUF_LEN:  prdata_o = APB_DW'(buf_len_q);
      default:      prdata_o = '0;
    endcase
  end

  // any write restarts every ring
  assign cfg_o.chan_cnt = chan_cnt_q;
  assign cfg_o.buf_len  = buf_len_q;
  assign cfg_o.clear    = wr_en;

endmodule

`default_nettype wire

// File: hw/rtl/mcorb_store.sv
// ----------------------------------------------------------------------------
// mcorb_store
// Sample memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcorb_store #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mcorb_adv.sv
// ----------------------------------------------------------------------------
// mcorb_adv
// Shared pointer unit: increment with wrap at ring length, compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mcorb_adv #(
  parameter int PTR_W = 10,
  parameter int LEN_W = 11
) (
  input  wire logic [PTR_W-1:0] ptr_i,
  input  wire logic [PTR_W-1:0] other_i,
  input  wire logic [LEN_W-1:0] len_i,
  output logic      [PTR_W-1:0] next_o,
  output logic                  hit_o
);

  logic [LEN_W-1:0] inc;

  assign inc    = LEN_W'(ptr_i) + LEN_W'(1);
  assign next_o = (inc >= len_i) ? '0 : PTR_W'(inc);
  assign hit_o  = (next_o == other_i);

endmodule

`default_nettype wire

// File: hw/rtl/mcorb_seq.sv
// ----------------------------------------------------------------------------
// mcorb_seq
// Request sequencer: channel pointers, loss flags and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcorb_seq #(
  parameter int MAX_CHANNELS = mcorb_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_DEPTH    = mcorb_pkg::DEF_MAX_DEPTH,
  parameter int MAX_BURST    = mcorb_pkg::DEF_MAX_BURST,
  parameter int SAMPLE_WIDTH = mcorb_pkg::DEF_SAMPLE_WIDTH,
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int PTR_W  = $clog2(MAX_DEPTH),
  localparam int LEN_W  = $clog2(MAX_DEPTH + 1),
  localparam int ADDR_W = CH_W + PTR_W
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mcorb_pkg::cfg_t         cfg_i,
  mcorb_req_if.sink                    req_i,
  mcorb_rsp_if.source                  rsp_o,
  output logic      [PTR_W-1:0]        adv_ptr_o,
  output logic      [PTR_W-1:0]        adv_other_o,
  output logic      [LEN_W-1:0]        adv_len_o,
  input  wire logic [PTR_W-1:0]        adv_next_i,
  input  wire logic                    adv_hit_i,
  output logic                         mem_we_o,
  output logic      [ADDR_W-1:0]       mem_waddr_o,
  output logic      [SAMPLE_WIDTH-1:0] mem_wdata_o,
  output logic                         mem_re_o,
  output logic      [ADDR_W-1:0]       mem_raddr_o,
  input  wire logic [SAMPLE_WIDTH-1:0] mem_rdata_i
);
  import mcorb_pkg::*;

  state_e               state_q, state_d;
  logic [CHANNEL_W-1:0] ch_q, ch_d;
  req_e                 type_q, type_d;
  logic [SAMPLE_W-1:0]  sample_q, sample_d;
  logic [COUNT_W-1:0]   want_q, want_d;
  logic [COUNT_W-1:0]   n_q, n_d;
  logic [PTR_W-1:0]     wpw_q, wpw_d;
  logic [PTR_W-1:0]     rpw_q, rpw_d;
  logic                 hit_q, hit_d;

  logic [PTR_W-1:0]     wptr_q [MAX_CHANNELS];
  logic [PTR_W-1:0]     wptr_d [MAX_CHANNELS];
  logic [PTR_W-1:0]     rptr_q [MAX_CHANNELS];
  logic [PTR_W-1:0]     rptr_d [MAX_CHANNELS];
  logic                 ovf_q  [MAX_CHANNELS];
  logic                 ovf_d  [MAX_CHANNELS];

  logic                 ovalid_q, ovalid_d;
  status_e              ostat_q, ostat_d;
  logic [SAMPLE_W-1:0]  odata_q, odata_d;
  logic [COUNT_W-1:0]   ocnt_q, ocnt_d;
  logic                 olast_q, olast_d;
  logic                 oloss_q, oloss_d;

  logic                 emit;
  status_e              e_stat;
  logic [SAMPLE_W-1:0]  e_data;
  logic [COUNT_W-1:0]   e_cnt;
  logic                 e_last;
  logic                 e_loss;

  logic [CH_W-1:0]      ci;
  logic [31:0]          ch_ext;
  logic [31:0]          cc_ext;
  logic [31:0]          act_ch;
  logic [31:0]          bl_ext;
  logic [31:0]          mc_ext;
  logic [COUNT_W-1:0]   want_sat;
  logic                 bad;
  logic                 out_free;
  logic                 rd_last;

  assign ci     = CH_W'(ch_q);
  assign ch_ext = 32'(ch_q);
  assign cc_ext = 32'(cfg_i.chan_cnt);
  assign act_ch = (cc_ext > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS) : cc_ext;
  assign bad    = (ch_ext >= act_ch) || (ch_ext >= 32'(MAX_CHANNELS));

  assign bl_ext    = 32'(cfg_i.buf_len);
  assign adv_len_o = (bl_ext < 32'd2)              ? LEN_W'(2) :
                     (bl_ext > 32'(MAX_DEPTH))     ? LEN_W'(MAX_DEPTH) :
                                                     LEN_W'(cfg_i.buf_len);

  assign mc_ext   = 32'(req_i.max_count);
  assign want_sat = (mc_ext == 32'd0)            ? COUNT_W'(1) :
                    (mc_ext > 32'(MAX_BURST))    ? COUNT_W'(MAX_BURST) :
                                                   req_i.max_count;

  // the shared unit advances the write pointer only while in ST_WADV
  assign adv_ptr_o   = (state_q == ST_WADV) ? wpw_q : rpw_q;
  assign adv_other_o = (state_q == ST_WADV) ? rpw_q : wpw_q;

  assign out_free = !ovalid_q || rsp_o.ready;
  assign rd_last  = hit_q || (n_q == want_q);

  assign req_i.ready = (state_q == ST_IDLE);

  assign mem_waddr_o = {ci, wptr_q[ci]};
  assign mem_wdata_o = SAMPLE_WIDTH'(sample_q);
  assign mem_raddr_o = {ci, rpw_q};

  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    type_d   = type_q;
    sample_d = sample_q;
    want_d   = want_q;
    n_d      = n_q;
    wpw_d    = wpw_q;
    rpw_d    = rpw_q;
    hit_d    = hit_q;
    wptr_d   = wptr_q;
    rptr_d   = rptr_q;
    ovf_d    = ovf_q;
    emit     = 1'b0;
    e_stat   = STAT_WRITE;
    e_data   = '0;
    e_cnt    = '0;
    e_last   = 1'b1;
    e_loss   = 1'b0;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          ch_d     = req_i.channel;
          type_d   = req_e'(req_i.req_type);
          sample_d = req_i.sample;
          want_d   = want_sat;
          n_d      = '0;
          state_d  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (bad) begin
          if (out_free) begin
            emit    = 1'b1;
            e_stat  = STAT_BAD;
            state_d = ST_IDLE;
          end
        end else begin
          wpw_d = wptr_q[ci];
          rpw_d = rptr_q[ci];
          if (type_q == REQ_WRITE) begin
            mem_we_o = 1'b1;
            state_d  = ST_WADV;
          end else if (wptr_q[ci] == rptr_q[ci]) begin
            if (out_free) begin
              emit    = 1'b1;
              e_stat  = STAT_EMPTY;
              e_loss  = ovf_q[ci];
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_RADDR;
          end
        end
      end
      ST_WADV: begin
        wpw_d   = adv_next_i;
        state_d = adv_hit_i ? ST_WDROP : ST_WRES;
      end
      ST_WDROP: begin
        // ring full: drop the oldest sample
        rpw_d     = adv_next_i;
        ovf_d[ci] = 1'b1;
        state_d   = ST_WRES;
      end
      ST_WRES: begin
        if (out_free) begin
          wptr_d[ci] = wpw_q;
          rptr_d[ci] = rpw_q;
          emit       = 1'b1;
          e_stat     = STAT_WRITE;
          e_loss     = ovf_q[ci];
          state_d    = ST_IDLE;
        end
      end
      ST_RADDR: begin
        mem_re_o = 1'b1;
        rpw_d    = adv_next_i;
        hit_d    = adv_hit_i;
        n_d      = n_q + COUNT_W'(1);
        state_d  = ST_RDATA;
      end
      ST_RDATA: begin
        if (out_free) begin
          emit   = 1'b1;
          e_stat = STAT_DATA;
          e_data = SAMPLE_W'(mem_rdata_i);
          e_cnt  = n_q;
          e_last = rd_last;
          e_loss = ovf_q[ci];
          if (rd_last) begin
            rptr_d[ci] = rpw_q;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_RADDR;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_i.clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        wptr_d[i] = '0;
        rptr_d[i] = '0;
        ovf_d[i]  = 1'b0;
      end
    end
  end

  always_comb begin
    ovalid_d = emit ? 1'b1 : (ovalid_q && !rsp_o.ready);
    ostat_d  = emit ? e_stat : ostat_q;
    odata_d  = emit ? e_data : odata_q;
    ocnt_d   = emit ? e_cnt  : ocnt_q;
    olast_d  = emit ? e_last : olast_q;
    oloss_d  = emit ? e_loss : oloss_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        wptr_q[i] <= '0;
        rptr_q[i] <= '0;
        ovf_q[i]  <= 1'b0;
      end
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      wptr_q   <= wptr_d;
      rptr_q   <= rptr_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    type_q   <= type_d;
    sample_q <= sample_d;
    want_q   <= want_d;
    n_q      <= n_d;
    wpw_q    <= wpw_d;
    rpw_q    <= rpw_d;
    hit_q    <= hit_d;
    ostat_q  <= ostat_d;
    odata_q  <= odata_d;
    ocnt_q   <= ocnt_d;
    olast_q  <= olast_d;
    oloss_q  <= oloss_d;
  end

  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.status     = ostat_q;
  assign rsp_o.read_data  = odata_q;
  assign rsp_o.read_count = ocnt_q;
  assign rsp_o.last       = olast_q;
  assign rsp_o.loss_flag  = oloss_q;

endmodule

`default_nettype wire

// File: verif/tb_multichannel_overwrite_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// tb_multichannel_overwrite_ring_buffer_top
// Self-checking bench for the overwrite-oldest multichannel sample rings.
// Drives write and burst-read requests and programs the channel count and
// ring length over APB, with random gaps and stalls on both streams. A shadow
// of every ring predicts the result stream, which is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multichannel_overwrite_ring_buffer_top;
  import mcorb_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    status_e       status;
    logic [31:0]   data;
    logic [6:0]    count;
    logic          last;
    logic          loss;
  } ring_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mcorb_req_if req_bus ();
  mcorb_rsp_if rsp_bus ();

  multichannel_overwrite_ring_buffer_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the rings
  logic [CHAN_CNT_W-1:0] cfg_channels;
  logic [BUF_LEN_W-1:0]  cfg_len;
  int unsigned           shadow_wp      [DEF_MAX_CHANNELS];
  int unsigned           shadow_rp      [DEF_MAX_CHANNELS];
  logic                  shadow_lost    [DEF_MAX_CHANNELS];
  logic [31:0]           shadow_samples [DEF_MAX_CHANNELS][DEF_MAX_DEPTH];

  ring_result_t results_due[$];
  ring_result_t got_result;
  ring_result_t want_result;
  int           error_cnt    = 0;
  int           stall_cycles = 0;
  bit           steady       = 1'b0;

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic int unsigned active_channels();
    return (cfg_channels > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : cfg_channels;
  endfunction

  function automatic int unsigned slot_after(int unsigned p, int unsigned len);
    return (p + 1 >= len) ? 0 : p + 1;
  endfunction

  function automatic void clear_rings();
    for (int c = 0; c < DEF_MAX_CHANNELS; c++) begin
      shadow_wp[c]   = 0;
      shadow_rp[c]   = 0;
      shadow_lost[c] = 1'b0;
    end
  endfunction

  function automatic void ring_apply_request(req_e kind, logic [2:0] ch,
                                             logic [31:0] smp, logic [6:0] want);
    int unsigned  len;
    int unsigned  wp;
    int unsigned  rp;
    int unsigned  n;
    int unsigned  lim;
    ring_result_t res;
    len = (cfg_len < 2) ? 2 : ((cfg_len > DEF_MAX_DEPTH) ? DEF_MAX_DEPTH : cfg_len);
    if (ch >= active_channels()) begin
      results_due.push_back('{STAT_BAD, 32'd0, 7'd0, 1'b1, 1'b0});
      return;
    end
    wp = shadow_wp[ch];
    rp = shadow_rp[ch];
    if (kind == REQ_WRITE) begin
      shadow_samples[ch][wp] = smp;
      wp = slot_after(wp, len);
      if (wp == rp) begin
        rp = slot_after(rp, len);
        shadow_lost[ch] = 1'b1;
      end
      shadow_wp[ch] = wp;
      shadow_rp[ch] = rp;
      results_due.push_back('{STAT_WRITE, 32'd0, 7'd0, 1'b1, shadow_lost[ch]});
      return;
    end
    if (rp == wp) begin
      results_due.push_back('{STAT_EMPTY, 32'd0, 7'd0, 1'b1, shadow_lost[ch]});
      return;
    end
    lim = (want == 0) ? 1 : ((want > DEF_MAX_BURST) ? DEF_MAX_BURST : want);
    n = 0;
    while (rp != wp && n < lim) begin
      res.status = STAT_DATA;
      res.data   = shadow_samples[ch][rp];
      rp         = slot_after(rp, len);
      n++;
      res.count  = 7'(n);
      res.last   = (rp == wp) || (n == lim);
      res.loss   = shadow_lost[ch];
      results_due.push_back(res);
    end
    shadow_rp[ch] = rp;
  endfunction

  task automatic send_request(req_e kind, logic [2:0] ch, logic [31:0] smp,
                              logic [6:0] cnt);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= kind;
    req_bus.channel   <= ch;
    req_bus.sample    <= smp;
    req_bus.max_count <= cnt;
    do @(posedge clk_i); while (!req_bus.ready);
    ring_apply_request(kind, ch, smp, cnt);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(reg_e idx, logic [31:0] value);
    hold_until_drained();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_CHAN_CNT) begin
      cfg_channels = value[CHAN_CNT_W-1:0];
    end else begin
      cfg_len = value[BUF_LEN_W-1:0];
    end
    clear_rings();
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_random(int unsigned write_pct);
    int unsigned act;
    int unsigned r;
    logic [2:0]  ch;
    logic [31:0] smp;
    logic [6:0]  cnt;
    act = active_channels();
    if (act == 0 || $urandom_range(0, 99) < 8) ch = 3'($urandom_range(0, 7));
    else ch = 3'($urandom_range(0, act - 1));
    if ($urandom_range(0, 99) < write_pct) begin
      r = $urandom_range(0, 19);
      smp = (r == 0) ? 32'h0 : ((r == 1) ? 32'hFFFF_FFFF : $urandom());
      send_request(REQ_WRITE, ch, smp, 7'($urandom_range(0, 127)));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) cnt = 7'($urandom_range(1, 6));
      else if (r < 80) cnt = 7'($urandom_range(7, 64));
      else if (r < 90) cnt = 7'd0;
      else cnt = 7'($urandom_range(65, 127));
      send_request(REQ_READ, ch, $urandom(), cnt);
    end
  endtask

  task automatic test_reset_defaults();
    send_request(REQ_WRITE, 3'd0, 32'h0000_0000, 7'd1);
    send_request(REQ_WRITE, 3'd0, 32'hFFFF_FFFF, 7'd127);
    send_request(REQ_WRITE, 3'd5, 32'hA5A5_5A5A, 7'd0);
    send_request(REQ_READ,  3'd0, 32'h0, 7'd0);
    send_request(REQ_READ,  3'd0, 32'hFFFF_FFFF, 7'd127);
    send_request(REQ_READ,  3'd0, 32'h0, 7'd1);
    send_request(REQ_WRITE, 3'd6, 32'h1234_5678, 7'd1);
    send_request(REQ_READ,  3'd7, 32'h0, 7'd64);
    send_request(REQ_READ,  3'd5, 32'h0, 7'd64);
  endtask

  task automatic test_saturation_and_overflow();
    // channel count above range and ring length below range
    write_register(REG_CHAN_CNT, 32'hFFFF_FFFF);
    write_register(REG_BUF_LEN, 32'h0);
    send_request(REQ_WRITE, 3'd7, 32'h0000_0001, 7'd1);
    send_request(REQ_WRITE, 3'd7, 32'h8000_0000, 7'd1);
    send_request(REQ_READ,  3'd7, 32'h0, 7'd64);
    send_request(REQ_READ,  3'd7, 32'h0, 7'd64);
    send_request(REQ_WRITE, 3'd3, 32'hDEAD_BEEF, 7'd1);
    send_request(REQ_READ,  3'd3, 32'h0, 7'd2);
    // no active channel at all
    write_register(REG_CHAN_CNT, 32'h0);
    send_request(REQ_WRITE, 3'd0, 32'h5555_AAAA, 7'd1);
    send_request(REQ_READ,  3'd3, 32'h0, 7'd1);
    // single channel, ring length above range
    write_register(REG_CHAN_CNT, 32'h1);
    write_register(REG_BUF_LEN, 32'h7FF);
    send_request(REQ_WRITE, 3'd0, 32'h0F0F_F0F0, 7'd1);
    send_request(REQ_READ,  3'd1, 32'h0, 7'd1);
    send_request(REQ_READ,  3'd0, 32'h0, 7'd3);
  endtask

  task automatic test_long_burst();
    write_register(REG_CHAN_CNT, 32'd2);
    write_register(REG_BUF_LEN, 32'd1024);
    steady = 1'b1;
    for (int i = 0; i < 70; i++) begin
      if (i == 35) steady = 1'b0;
      send_request(REQ_WRITE, 3'd1, $urandom(), 7'd1);
    end
    send_request(REQ_READ, 3'd1, 32'h0, 7'($urandom_range(65, 127)));
    send_request(REQ_READ, 3'd1, 32'h0, 7'd64);
    send_request(REQ_READ, 3'd1, 32'h0, 7'd64);
  endtask

  task automatic test_random_configs();
    int unsigned chan_set [8] = '{4, 8, 2, 1, 9, 6, 3, 0};
    int unsigned len_set  [8] = '{3, 16, 70, 5, 1024, 600, 1, 8};
    for (int p = 0; p < 8; p++) begin
      if (p != 5) write_register(REG_CHAN_CNT, chan_set[p]);
      write_register(REG_BUF_LEN, len_set[p]);
      steady = (p % 3 == 1);
      for (int i = 0; i < 24; i++) begin
        if (i == 12) hold_until_drained();
        send_random((len_set[p] > 60) ? 70 : 55);
      end
    end
    steady = 1'b0;
  endtask

  // receiver stalls
  initial begin
    int unsigned n;
    rsp_bus.ready = 1'b0;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk_i);
        rsp_bus.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      rsp_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got_result = '{status_e'(rsp_bus.status), rsp_bus.read_data, rsp_bus.read_count,
                     rsp_bus.last, rsp_bus.loss_flag};
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result st=%0d data=%h cnt=%0d last=%b loss=%b",
                 $time, got_result.status, got_result.data, got_result.count,
                 got_result.last, got_result.loss);
        error_cnt++;
      end else begin
        want_result = results_due.pop_front();
        if (got_result !== want_result) begin
          $display("%0t: expected st=%0d data=%h cnt=%0d last=%b loss=%b", $time,
                   want_result.status, want_result.data, want_result.count,
                   want_result.last, want_result.loss);
          $display("%0t: actual   st=%0d data=%h cnt=%0d last=%b loss=%b", $time,
                   got_result.status, got_result.data, got_result.count,
                   got_result.last, got_result.loss);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_bus.valid     = 1'b0;
    req_bus.req_type  = REQ_WRITE;
    req_bus.channel   = '0;
    req_bus.sample    = '0;
    req_bus.max_count = '0;
    cfg_channels      = CHAN_CNT_RST;
    cfg_len           = BUF_LEN_RST;
    clear_rings();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_saturation_and_overflow();
    test_long_burst();
    test_random_configs();

    hold_until_drained();
    repeat (20) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
